/* src/pct_pkg.sv */
// Package for the presence change tracker.
// Holds table sizing, field widths, result codes, FSM states and cell structs.
`default_nettype none
package pct_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SLOT_W      = 5;
  localparam int KEY_W       = 64;
  localparam int STAMP_W     = 32;
  localparam int SIZE_W      = 32;
  localparam int EVENT_W     = 2;

  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [EVENT_W-1:0] EV_ADDED   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_CHANGED = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DELETED = 2'd2;
  localparam logic [EVENT_W-1:0] EV_DONE    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_DONE
  } pct_state_e;

  typedef struct packed {
    logic lookup;
    logic any_hit;
    logic commit;
  } pct_cell_ctl_t;

  typedef struct packed {
    logic hit_sel;
    logic free_sel;
    logic stamp_diff;
  } pct_cell_stat_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
    logic [SIZE_W-1:0]  size;
    logic               prev;
    logic               cur;
  } pct_view_t;

endpackage
`default_nettype wire

/* src/pct_if.sv */
// Handshake interfaces for observe transactions and result transactions.
// Depends on pct_pkg for the field widths.
`default_nettype none
interface pct_obs_if
  import pct_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [KEY_W-1:0]   item_key;
  logic [STAMP_W-1:0] item_stamp;
  logic [SIZE_W-1:0]  item_size;

  modport source (output valid, kind, item_key, item_stamp, item_size, input ready);
  modport sink   (input valid, kind, item_key, item_stamp, item_size, output ready);
endinterface

interface pct_res_if
  import pct_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic [SLOT_W-1:0]  slot;
  logic [KEY_W-1:0]   out_key;
  logic [STAMP_W-1:0] out_stamp;
  logic [SIZE_W-1:0]  out_size;
  logic               last;

  modport source (output valid, event_res, slot, out_key, out_stamp, out_size, last,
                  input ready);
  modport sink   (input valid, event_res, slot, out_key, out_stamp, out_size, last,
                  output ready);
endinterface
`default_nettype wire

/* src/presence_change_tracker.sv */
// Observe transaction: accepted in ST_IDLE, looked up in ST_LOOKUP once the output is free.
// Its result, if any, is held in an output register; the next item waits for the lookup.
// End of scan: a slot counter sweeps the cell row, then a closing result commits the seen flags.
// Reset clears all seen flags at once; stored entries are not cleared.
// Top level of the presence change tracker; depends on pct_pkg, pct_if and pct_cell.
`default_nettype none
module presence_change_tracker
  import pct_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pct_obs_if.sink    obs_i,
  pct_res_if.source  res_o
);

  pct_state_e         state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               req_kind_q;
  logic [KEY_W-1:0]   req_key_q;
  logic [STAMP_W-1:0] req_stamp_q;
  logic [SIZE_W-1:0]  req_size_q;

  logic               out_valid_q, out_valid_d;
  logic [EVENT_W-1:0] out_event_q, out_event_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic [KEY_W-1:0]   out_key_q, out_key_d;
  logic [STAMP_W-1:0] out_stamp_q, out_stamp_d;
  logic [SIZE_W-1:0]  out_size_q, out_size_d;
  logic               out_last_q, out_last_d;
  logic               out_load, out_free, in_accept;

  pct_cell_ctl_t      ctl;
  pct_cell_stat_t     stat [TABLE_DEPTH];
  pct_view_t          view [TABLE_DEPTH];
  pct_view_t          view_sel;
  logic [TABLE_DEPTH:0] hit_chain, free_chain;
  logic [TABLE_DEPTH-1:0] grant_vec;
  logic               any_hit, any_free, changed, emit;
  logic [IDX_W-1:0]   grant_idx;
  logic [IDX_W+SLOT_W-1:0] grant_wide, sweep_wide;

  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pct_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .req_key_i     (req_key_q),
      .req_stamp_i   (req_stamp_q),
      .req_size_i    (req_size_q),
      .hit_before_i  (hit_chain[i]),
      .free_before_i (free_chain[i]),
      .hit_before_o  (hit_chain[i+1]),
      .free_before_o (free_chain[i+1]),
      .stat_o        (stat[i]),
      .view_o        (view[i])
    );
  end

  assign any_hit  = hit_chain[TABLE_DEPTH];
  assign any_free = free_chain[TABLE_DEPTH];

  always_comb begin
    grant_idx = '0;
    changed   = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      grant_vec[i] = any_hit ? stat[i].hit_sel : stat[i].free_sel;
      if (grant_vec[i]) begin
        grant_idx = grant_idx | IDX_W'(i);
      end
      changed = changed | (stat[i].hit_sel & stat[i].stamp_diff);
    end
  end

  assign emit       = any_hit ? changed : any_free;
  assign grant_wide = {{SLOT_W{1'b0}}, grant_idx};
  assign sweep_wide = {{SLOT_W{1'b0}}, idx_q};
  assign view_sel   = view[idx_q];
  assign out_free   = !out_valid_q || res_o.ready;
  assign in_accept  = obs_i.valid && obs_i.ready;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    obs_i.ready = 1'b0;
    ctl.lookup  = 1'b0;
    ctl.any_hit = any_hit;
    ctl.commit  = 1'b0;
    out_load    = 1'b0;
    out_event_d = EV_DONE;
    out_slot_d  = '0;
    out_key_d   = '0;
    out_stamp_d = '0;
    out_size_d  = '0;
    out_last_d  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        obs_i.ready = 1'b1;
        if (obs_i.valid) begin
          if (obs_i.kind == KIND_END) begin
            state_d = ST_SWEEP;
            idx_d   = '0;
          end else begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          ctl.lookup  = 1'b1;
          state_d     = ST_IDLE;
          out_load    = emit;
          out_event_d = any_hit ? EV_CHANGED : EV_ADDED;
          out_slot_d  = grant_wide[SLOT_W-1:0];
          out_key_d   = req_key_q;
          out_stamp_d = req_stamp_q;
          out_size_d  = req_size_q;
        end
      end
      ST_SWEEP: begin
        if (out_free) begin
          out_load    = view_sel.prev && !view_sel.cur;
          out_event_d = EV_DELETED;
          out_slot_d  = sweep_wide[SLOT_W-1:0];
          out_key_d   = view_sel.key;
          out_stamp_d = view_sel.stamp;
          out_size_d  = view_sel.size;
          out_last_d  = 1'b0;
          if (idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
            state_d = ST_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          ctl.commit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && !res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_kind_q  <= obs_i.kind;
      req_key_q   <= obs_i.item_key;
      req_stamp_q <= obs_i.item_stamp;
      req_size_q  <= obs_i.item_size;
    end
    if (out_load) begin
      out_event_q <= out_event_d;
      out_slot_q  <= out_slot_d;
      out_key_q   <= out_key_d;
      out_stamp_q <= out_stamp_d;
      out_size_q  <= out_size_d;
      out_last_q  <= out_last_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.event_res = out_event_q;
  assign res_o.slot      = out_slot_q;
  assign res_o.out_key   = out_key_q;
  assign res_o.out_stamp = out_stamp_q;
  assign res_o.out_size  = out_size_q;
  assign res_o.last      = out_last_q;

`ifndef SYNTHESIS
  a_grant_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.lookup |-> $onehot0(grant_vec))
    else $error("More than one slot granted in one lookup.");

  a_end_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && obs_i.kind == KIND_END) |=> (state_q == ST_SWEEP && idx_q == '0))
    else $error("End of scan did not start the sweep at slot zero.");

  a_commit_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |=> (out_valid_q && out_event_q == EV_DONE && out_last_q))
    else $error("Flag commit without a closing result.");

  a_deleted_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_event_q == EV_DELETED) |-> !out_last_q)
    else $error("Deleted result marked as last.");

  a_req_kind_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> (req_kind_q == KIND_OBSERVE))
    else $error("Lookup started for an end of scan transaction.");
`endif

endmodule
`default_nettype wire

/* src/pct_cell.sv */
// One table slot: stored entry, seen flags, key compare and priority chain link.
// Depends on pct_pkg.
`default_nettype none
module pct_cell
  import pct_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pct_cell_ctl_t      ctl_i,
  input  wire logic [KEY_W-1:0]   req_key_i,
  input  wire logic [STAMP_W-1:0] req_stamp_i,
  input  wire logic [SIZE_W-1:0]  req_size_i,
  input  wire logic               hit_before_i,
  input  wire logic               free_before_i,
  output logic                    hit_before_o,
  output logic                    free_before_o,
  output pct_cell_stat_t          stat_o,
  output pct_view_t               view_o
);

  logic [KEY_W-1:0]   key_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [SIZE_W-1:0]  size_q;
  logic               prev_q, prev_d;
  logic               cur_q, cur_d;
  logic               key_eq, is_free, hit_sel, free_sel, do_hit, do_add, stamp_diff;

  always_comb begin
    key_eq        = prev_q && (key_q == req_key_i);
    is_free       = !prev_q && !cur_q;
    hit_sel       = key_eq && !hit_before_i;
    free_sel      = is_free && !free_before_i;
    hit_before_o  = hit_before_i || key_eq;
    free_before_o = free_before_i || is_free;
    stamp_diff    = (stamp_q != req_stamp_i);
    do_hit        = ctl_i.lookup && hit_sel;
    do_add        = ctl_i.lookup && !ctl_i.any_hit && free_sel;

    stat_o.hit_sel    = hit_sel;
    stat_o.free_sel   = free_sel;
    stat_o.stamp_diff = stamp_diff;

    view_o.key   = key_q;
    view_o.stamp = stamp_q;
    view_o.size  = size_q;
    view_o.prev  = prev_q;
    view_o.cur   = cur_q;

    prev_d = prev_q;
    cur_d  = cur_q;
    if (ctl_i.commit) begin
      prev_d = cur_q;
      cur_d  = 1'b0;
    end else if (do_hit || do_add) begin
      cur_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      cur_q  <= 1'b0;
    end else begin
      prev_q <= prev_d;
      cur_q  <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_add) begin
      key_q <= req_key_i;
    end
    if (do_add || (do_hit && stamp_diff)) begin
      stamp_q <= req_stamp_i;
      size_q  <= req_size_i;
    end
  end

endmodule
`default_nettype wire
